/* design/httok_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// httok_pkg
// Shared types and constants of the HTTP request head tokenizer.
// ----------------------------------------------------------------------------
package httok_pkg;

    localparam int METHOD_BYTES_DEF = 7;
    localparam int PATH_BYTES_DEF   = 256;
    localparam int KEY_BYTES_DEF    = 64;
    localparam int VALUE_BYTES_DEF  = 256;

    localparam int RES_DEPTH = 4;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // method words, first character in the low byte
    localparam logic [47:0] MW_GET    = 48'h0000_0054_4547;
    localparam logic [47:0] MW_POST   = 48'h0000_5453_4F50;
    localparam logic [47:0] MW_DELETE = 48'h4554_454C_4544;
    localparam logic [47:0] MW_PUT    = 48'h0000_0054_5550;
    localparam logic [47:0] MW_PATCH  = 48'h0048_4354_4150;

    localparam logic [15:0] ML_GET    = 16'd3;
    localparam logic [15:0] ML_POST   = 16'd4;
    localparam logic [15:0] ML_DELETE = 16'd6;
    localparam logic [15:0] ML_PUT    = 16'd3;
    localparam logic [15:0] ML_PATCH  = 16'd5;

    localparam logic [2:0] MC_UNKNOWN = 3'd0;
    localparam logic [2:0] MC_GET     = 3'd1;
    localparam logic [2:0] MC_POST    = 3'd2;
    localparam logic [2:0] MC_DELETE  = 3'd3;
    localparam logic [2:0] MC_PUT     = 3'd4;
    localparam logic [2:0] MC_PATCH   = 3'd5;
    localparam logic [2:0] MC_OTHER   = 3'd6;

    typedef enum logic [3:0] {
        PH_METHOD  = 4'd0,
        PH_PATH    = 4'd1,
        PH_VERSION = 4'd2,
        PH_LINE    = 4'd3,
        PH_KEY     = 4'd4,
        PH_COLON   = 4'd5,
        PH_VALUE   = 4'd6,
        PH_EOL     = 4'd7,
        PH_BODY    = 4'd8,
        PH_ERROR   = 4'd9
    } phase_t;

    typedef enum logic [3:0] {
        CL_METHOD  = 4'd0,
        CL_PATH    = 4'd1,
        CL_SKIP    = 4'd2,
        CL_KEY     = 4'd3,
        CL_VALUE   = 4'd4,
        CL_DELIM   = 4'd5,
        CL_BODY    = 4'd6,
        CL_IGNORED = 4'd7,
        CL_TERM    = 4'd8
    } cls_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [3:0] byte_class;
        logic [2:0] method_code;
        logic       parse_ok;
        logic       error_seen;
        logic       last_of_run;
    } res_t;

    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } push_t;

endpackage

/* design/httok_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// httok_in_if
// Request byte channel: one byte per beat.
// ----------------------------------------------------------------------------
interface httok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

/* design/httok_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// httok_out_if
// Label channel: one labeled byte per beat.
// ----------------------------------------------------------------------------
interface httok_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [3:0] byte_class;
    logic [2:0] method_code;
    logic       parse_ok;
    logic       error_seen;
    logic       last_of_run;

    modport source (output valid, output out_byte, output byte_class, output method_code,
                    output parse_ok, output error_seen, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input byte_class, input method_code,
                    input parse_ok, input error_seen, input last_of_run, output ready);
endinterface

/* design/http_request_head_tokenizer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_head_tokenizer_core
// Labels HTTP request bytes: method, path, headers, delimiters and body.
// Output: each label is registered in the result queue before it is offered on out_ch.
// Throughput: one byte per cycle while the four-entry result queue has room for two
// labels; a byte that yields two labels (held CR) needs two out beats.
// Reset: asynchronous, clears parser state and empties the result queue.
// ----------------------------------------------------------------------------
module http_request_head_tokenizer_core #(
    parameter int METHOD_BYTES = httok_pkg::METHOD_BYTES_DEF,
    parameter int PATH_BYTES   = httok_pkg::PATH_BYTES_DEF,
    parameter int KEY_BYTES    = httok_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BYTES  = httok_pkg::VALUE_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    httok_in_if.sink     in_ch,
    httok_out_if.source  out_ch
);
    import httok_pkg::*;

    push_t push;
    logic  space;
    logic  fire;

    assign in_ch.ready = space;
    assign fire        = in_ch.valid & space;

    httok_step #(
        .METHOD_BYTES (METHOD_BYTES),
        .PATH_BYTES   (PATH_BYTES),
        .KEY_BYTES    (KEY_BYTES),
        .VALUE_BYTES  (VALUE_BYTES)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (in_ch.data_byte),
        .push      (push)
    );

    httok_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .space  (space),
        .out_ch (out_ch)
    );

endmodule

/* design/httok_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// httok_step
// Parser state and per-byte labeling; yields zero, one or two labels a beat.
// ----------------------------------------------------------------------------
module httok_step #(
    parameter int METHOD_BYTES = httok_pkg::METHOD_BYTES_DEF,
    parameter int PATH_BYTES   = httok_pkg::PATH_BYTES_DEF,
    parameter int KEY_BYTES    = httok_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BYTES  = httok_pkg::VALUE_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          data_byte,
    output httok_pkg::push_t    push
);
    import httok_pkg::*;

    localparam int MAX_A    = (METHOD_BYTES > PATH_BYTES) ? METHOD_BYTES : PATH_BYTES;
    localparam int MAX_B    = (KEY_BYTES > VALUE_BYTES) ? KEY_BYTES : VALUE_BYTES;
    localparam int MAX_SIZE = (MAX_A > MAX_B) ? MAX_A : MAX_B;
    localparam int LEN_W    = $clog2(MAX_SIZE);

    localparam logic [LEN_W-1:0] METH_LIM = LEN_W'(METHOD_BYTES - 1);
    localparam logic [LEN_W-1:0] PATH_LIM = LEN_W'(PATH_BYTES - 1);
    localparam logic [LEN_W-1:0] KEY_LIM  = LEN_W'(KEY_BYTES - 1);
    localparam logic [LEN_W-1:0] VAL_LIM  = LEN_W'(VALUE_BYTES - 1);

    typedef struct packed {
        phase_t           phase;
        logic [LEN_W-1:0] len;
        logic [47:0]      chars;
        logic [2:0]       mres;
        logic             err;
    } st_t;

    typedef struct packed {
        st_t  st;
        cls_t cls;
    } feed_t;

    localparam st_t ST_RESET = '{phase: PH_METHOD, len: '0, chars: '0,
                                 mres: MC_UNKNOWN, err: 1'b0};

    st_t   st_reg, st_next;
    logic  cr_reg, cr_next;
    st_t   st_key;
    st_t   base;
    st_t   lf_st;
    feed_t fa;
    feed_t fb;
    logic  clean;
    res_t  term;

    function automatic logic [2:0] match_method(st_t s);
        logic [15:0] l;
        l = 16'(s.len);
        if (l == ML_GET && s.chars == MW_GET)
            return MC_GET;
        if (l == ML_POST && s.chars == MW_POST)
            return MC_POST;
        if (l == ML_DELETE && s.chars == MW_DELETE)
            return MC_DELETE;
        if (l == ML_PUT && s.chars == MW_PUT)
            return MC_PUT;
        if (l == ML_PATCH && s.chars == MW_PATCH)
            return MC_PATCH;
        return MC_OTHER;
    endfunction

    function automatic feed_t field_step(st_t s, logic [7:0] b, logic [7:0] delim,
                                         logic [LEN_W-1:0] lim, cls_t c, phase_t nx);
        feed_t f;
        f.st  = s;
        f.cls = c;
        if (b == delim)
        begin
            f.st.len   = '0;
            f.st.phase = nx;
            f.cls      = CL_DELIM;
        end
        else if (s.len >= lim)
        begin
            f.st.err   = 1'b1;
            f.st.phase = PH_ERROR;
            f.cls      = CL_IGNORED;
        end
        else
        begin
            f.st.len = s.len + LEN_W'(1);
        end
        return f;
    endfunction

    function automatic feed_t feed(st_t s, logic [7:0] b);
        feed_t f;
        st_t   t;
        f.st  = s;
        f.cls = CL_IGNORED;
        t     = s;
        case (s.phase)
            PH_METHOD:
            begin
                if (b == CH_SP)
                begin
                    f.st.mres  = match_method(s);
                    f.st.len   = '0;
                    f.st.phase = PH_PATH;
                    f.cls      = CL_DELIM;
                end
                else if (s.len >= METH_LIM)
                begin
                    f.st.err   = 1'b1;
                    f.st.phase = PH_ERROR;
                end
                else
                begin
                    for (int k = 0; k < 6; k++)
                    begin
                        if (16'(s.len) == 16'(k))
                            f.st.chars[8*k +: 8] = b;
                    end
                    f.st.len = s.len + LEN_W'(1);
                    f.cls    = CL_METHOD;
                end
            end
            PH_PATH:
                f = field_step(s, b, CH_SP, PATH_LIM, CL_PATH, PH_VERSION);
            PH_VERSION, PH_EOL:
            begin
                if (b == CH_LF)
                begin
                    f.st.phase = PH_LINE;
                    f.cls      = CL_DELIM;
                end
                else
                begin
                    f.cls = CL_SKIP;
                end
            end
            PH_LINE, PH_KEY:
            begin
                t.phase = PH_KEY;
                f = field_step(t, b, CH_COLON, KEY_LIM, CL_KEY, PH_COLON);
            end
            PH_COLON:
            begin
                t.phase = PH_VALUE;
                if (b == CH_SP)
                begin
                    f.st  = t;
                    f.cls = CL_DELIM;
                end
                else
                begin
                    f = field_step(t, b, CH_CR, VAL_LIM, CL_VALUE, PH_EOL);
                end
            end
            PH_VALUE:
                f = field_step(s, b, CH_CR, VAL_LIM, CL_VALUE, PH_EOL);
            PH_BODY:
                f.cls = CL_BODY;
            default:
                f.cls = CL_IGNORED;
        endcase
        return f;
    endfunction

    function automatic res_t mk_res(logic [7:0] b, cls_t c, st_t s, logic ok, logic last);
        res_t r;
        r.out_byte    = b;
        r.byte_class  = c;
        r.method_code = s.mres;
        r.parse_ok    = ok;
        r.error_seen  = s.err;
        r.last_of_run = last;
        return r;
    endfunction

    always_comb
    begin
        st_key       = st_reg;
        st_key.phase = PH_KEY;
        fa           = feed(st_key, CH_CR);
        base         = cr_reg ? fa.st : st_reg;
        fb           = feed(base, data_byte);
        lf_st        = st_reg;
        lf_st.phase  = PH_BODY;

        clean = (base.phase == PH_LINE) || (base.phase == PH_BODY);
        term  = '{out_byte: CH_NUL, byte_class: CL_TERM, method_code: base.mres,
                  parse_ok: clean & ~base.err, error_seen: base.err | ~clean,
                  last_of_run: 1'b1};

        push.cnt = 2'd0;
        push.r0  = mk_res(data_byte, fb.cls, fb.st, 1'b0, 1'b1);
        push.r1  = term;
        st_next  = st_reg;
        cr_next  = cr_reg;

        if (data_byte == CH_NUL)
        begin
            st_next = ST_RESET;
            cr_next = 1'b0;
            if (cr_reg)
            begin
                push.cnt = 2'd2;
                push.r0  = mk_res(CH_CR, fa.cls, fa.st, 1'b0, 1'b0);
                push.r1  = term;
            end
            else
            begin
                push.cnt = 2'd1;
                push.r0  = term;
            end
        end
        else if (cr_reg)
        begin
            cr_next  = 1'b0;
            push.cnt = 2'd2;
            if (data_byte == CH_LF)
            begin
                st_next = lf_st;
                push.r0 = mk_res(CH_CR, CL_DELIM, lf_st, 1'b0, 1'b0);
                push.r1 = mk_res(CH_LF, CL_DELIM, lf_st, 1'b0, 1'b1);
            end
            else
            begin
                st_next = fb.st;
                push.r0 = mk_res(CH_CR, fa.cls, fa.st, 1'b0, 1'b0);
                push.r1 = mk_res(data_byte, fb.cls, fb.st, 1'b0, 1'b1);
            end
        end
        else if (st_reg.phase == PH_LINE && data_byte == CH_CR)
        begin
            cr_next = 1'b1;
        end
        else
        begin
            push.cnt = 2'd1;
            st_next  = fb.st;
        end

        if (!fire)
        begin
            push.cnt = 2'd0;
            st_next  = st_reg;
            cr_next  = cr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_RESET;
            cr_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            cr_reg <= cr_next;
        end
    end

endmodule

/* design/httok_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// httok_outq
// Result queue: takes up to two labels a cycle, hands out one a beat.
// ----------------------------------------------------------------------------
module httok_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  httok_pkg::push_t    push,
    output logic                space,
    httok_out_if.source         out_ch
);
    import httok_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    res_t             mem_reg [RES_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;
    res_t             head;

    assign pop   = out_ch.valid & out_ch.ready;
    assign space = (cnt_reg <= CNT_W'(RES_DEPTH - 2));
    assign head  = mem_reg[rd_reg];

    assign out_ch.valid       = (cnt_reg != '0);
    assign out_ch.out_byte    = head.out_byte;
    assign out_ch.byte_class  = head.byte_class;
    assign out_ch.method_code = head.method_code;
    assign out_ch.parse_ok    = head.parse_ok;
    assign out_ch.error_seen  = head.error_seen;
    assign out_ch.last_of_run = head.last_of_run;

    always_comb
    begin
        wr_next  = wr_reg + PTR_W'(push.cnt);
        rd_next  = rd_reg + PTR_W'(pop);
        cnt_next = cnt_reg + CNT_W'(push.cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem_reg[wr_reg] <= push.r0;
        if (push.cnt == 2'd2)
            mem_reg[wr_reg + PTR_W'(1)] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* design/httok_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// httok_port_checks
// Port-level checks of the tokenizer core, bound to the top level.
// ----------------------------------------------------------------------------
module httok_port_checks (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [3:0] byte_class,
    input logic [2:0] method_code,
    input logic       parse_ok,
    input logic       error_seen,
    input logic       last_of_run
);
    import httok_pkg::*;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(byte_class) && $stable(method_code) && $stable(parse_ok)
            && $stable(error_seen) && $stable(last_of_run))
        else $error("label beat changed while stalled");

    a_ok_on_term: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_ok |-> byte_class == CL_TERM)
        else $error("parse_ok outside terminator beat");

    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_class == CL_TERM |-> last_of_run && out_byte == CH_NUL)
        else $error("terminator beat not last or nonzero");

    a_ok_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_ok |-> !error_seen)
        else $error("parse_ok with error set");

endmodule

bind http_request_head_tokenizer_core httok_port_checks u_httok_port_checks (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .byte_class  (out_ch.byte_class),
    .method_code (out_ch.method_code),
    .parse_ok    (out_ch.parse_ok),
    .error_seen  (out_ch.error_seen),
    .last_of_run (out_ch.last_of_run)
);
